// File: rtl/aovg_pkg.sv
// ----------------------------------------------------------------------------
// aovg_pkg: shared types and constants of the arc outline vertex generator
// widths, cordic angle table, register indexes and pipeline latencies
// ----------------------------------------------------------------------------
package aovg_pkg;

	// arc point limit and cordic depth
	localparam int MAX_POINTS   = 1024;
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;

	// register file
	localparam int WR_DW = 20;
	localparam int WR_IW = 3;

	typedef enum logic [WR_IW-1:0] {
		REG_RADIUS      = 3'd0,
		REG_POINT_COUNT = 3'd1,
		REG_START_ANGLE = 3'd2,
		REG_END_ANGLE   = 3'd3,
		REG_THICKNESS   = 3'd4
	} reg_index_t;

	// angle phase divider
	localparam int KW  = 11;   // point index, up to N+1
	localparam int RGW = 10;   // angle range
	localparam int BSW = 9;    // base angle 0..359
	localparam int AW  = 21;   // phase numerator
	localparam int DW  = 19;   // 360*N
	localparam int PHW = 32;   // binary phase per turn
	localparam int DIV_STEPS = AW + PHW;

	// cordic and point coordinates
	localparam int XW = 33;
	localparam int ZW = 33;
	localparam int RW_RAD = 20;
	localparam int PW = XW + RW_RAD + 1;
	localparam int CW = 23;
	localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(64'd652032874);

	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// segment normal
	localparam int NW   = 23;          // normal component
	localparam int MW   = NW;          // its magnitude
	localparam int SW   = 2 * NW;      // squared length
	localparam int SQW  = SW + 16;     // sqrt operand
	localparam int RTW  = SQW / 2;     // root
	localparam int RMW  = RTW + 3;     // sqrt remainder
	localparam int QW   = 18;          // unit quotient before rounding
	localparam int DVW  = MW + 25;     // unit dividend
	localparam int UW   = QW + 1;      // signed unit component

	// output offset
	localparam int TW = 16;
	localparam int OW = UW + 1 + TW;
	localparam int OUTW = 24;

	// latencies in cycles
	localparam int PT_LAT = 1 + DIV_STEPS + 1 + CORDIC_STEPS + 3;
	localparam int NM_LAT = 3 + RTW + QW + 1;
	localparam int TOT_LAT = PT_LAT + NM_LAT + 2;

	typedef struct packed {
		logic [RW_RAD-1:0] radius;
		logic [RGW-1:0]    range;
		logic [DW-1:0]     nbase;
		logic [DW-1:0]     divisor;
	} arc_cfg_t;

	typedef struct packed {
		logic [MW-1:0] mx;
		logic [MW-1:0] my;
		logic          sx;
		logic          sy;
	} nrm_side_t;

endpackage

// File: rtl/aovg_point.sv
// ----------------------------------------------------------------------------
// aovg_point: arc point position pipeline
// phase by restoring division, cordic rotation, scaling by the radius
// ----------------------------------------------------------------------------
module aovg_point (
	input  logic                                  clk,
	input  aovg_pkg::arc_cfg_t                    cfg,
	input  logic [aovg_pkg::KW-1:0]               k,
	output logic signed [aovg_pkg::CW-1:0]        px,
	output logic signed [aovg_pkg::CW-1:0]        py
);
	localparam int AW = aovg_pkg::AW;
	localparam int DW = aovg_pkg::DW;
	localparam int PHW = aovg_pkg::PHW;
	localparam int NDIV = aovg_pkg::DIV_STEPS;
	localparam int NCOR = aovg_pkg::CORDIC_STEPS;
	localparam int XW = aovg_pkg::XW;
	localparam int ZW = aovg_pkg::ZW;
	localparam int PW = aovg_pkg::PW;
	localparam int CW = aovg_pkg::CW;
	localparam logic signed [PW-1:0] RND = PW'(64'd536870912);

	// numerator k*range + n*base
	logic [AW-1:0] kr;
	logic [AW-1:0] num_s1;

	assign kr = AW'(k) * AW'(cfg.range);

	always_ff @(posedge clk) begin
		num_s1 <= kr + AW'(cfg.nbase);
	end

	// long division, one quotient bit per stage; the low phase bits survive
	logic [AW-1:0]  dv_num_s [NDIV];
	logic [DW-1:0]  dv_rem_s [NDIV];
	logic [PHW-1:0] dv_q_s   [NDIV];

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		logic [AW-1:0]  num_in;
		logic [DW-1:0]  rem_in;
		logic [PHW-1:0] q_in;
		logic [DW:0]    trial;
		logic           ge;

		if (j == 0) begin : g_first
			assign num_in = num_s1;
			assign rem_in = '0;
			assign q_in   = '0;
		end else begin : g_next
			assign num_in = dv_num_s[j-1];
			assign rem_in = dv_rem_s[j-1];
			assign q_in   = dv_q_s[j-1];
		end

		assign trial = {rem_in, num_in[AW-1]};
		assign ge    = trial >= {1'b0, cfg.divisor};

		always_ff @(posedge clk) begin
			dv_num_s[j] <= num_in << 1;
			dv_rem_s[j] <= ge ? DW'(trial - {1'b0, cfg.divisor}) : DW'(trial);
			dv_q_s[j]   <= {q_in[PHW-2:0], ge};
		end
	end

	// quadrant reduction
	logic [PHW-1:0]        phase;
	logic [1:0]            quad;
	logic [PHW-1:0]        zu;
	logic [1:0]            quad_s;
	logic signed [ZW-1:0]  z0_s;

	assign phase = dv_q_s[NDIV-1];
	assign quad  = 2'((phase + 32'h2000_0000) >> 30);
	assign zu    = phase - {quad, 30'b0};

	always_ff @(posedge clk) begin
		quad_s <= quad;
		z0_s   <= signed'({zu[PHW-1], zu});
	end

	// rotation stages
	logic signed [XW-1:0] cx_s [NCOR];
	logic signed [XW-1:0] cy_s [NCOR];
	logic signed [ZW-1:0] cz_s [NCOR];
	logic [1:0]           cq_s [NCOR];

	for (genvar j = 0; j < NCOR; j++) begin : g_cor
		logic signed [XW-1:0] x_in, y_in, xs, ys;
		logic signed [ZW-1:0] z_in, atn;
		logic [1:0]           q_in;

		if (j == 0) begin : g_first
			assign x_in = aovg_pkg::CORDIC_GAIN;
			assign y_in = '0;
			assign z_in = z0_s;
			assign q_in = quad_s;
		end else begin : g_next
			assign x_in = cx_s[j-1];
			assign y_in = cy_s[j-1];
			assign z_in = cz_s[j-1];
			assign q_in = cq_s[j-1];
		end

		assign xs  = x_in >>> j;
		assign ys  = y_in >>> j;
		assign atn = signed'({1'b0, aovg_pkg::ATAN_TAB[j]});

		always_ff @(posedge clk) begin
			if (!z_in[ZW-1]) begin
				cx_s[j] <= x_in - ys;
				cy_s[j] <= y_in + xs;
				cz_s[j] <= z_in - atn;
			end else begin
				cx_s[j] <= x_in + ys;
				cy_s[j] <= y_in - xs;
				cz_s[j] <= z_in + atn;
			end
			cq_s[j] <= q_in;
		end
	end

	// quadrant restore
	logic signed [XW-1:0] rx, ry, cos_s, sin_s;

	assign rx = cx_s[NCOR-1];
	assign ry = cy_s[NCOR-1];

	always_ff @(posedge clk) begin
		case (cq_s[NCOR-1])
			2'd0: begin
				cos_s <= rx;
				sin_s <= ry;
			end
			2'd1: begin
				cos_s <= -ry;
				sin_s <= rx;
			end
			2'd2: begin
				cos_s <= -rx;
				sin_s <= -ry;
			end
			default: begin
				cos_s <= ry;
				sin_s <= -rx;
			end
		endcase
	end

	// scale by the radius, round, offset by the radius
	logic signed [aovg_pkg::RW_RAD:0] rad;
	logic signed [PW-1:0]             mx, my, prod_x_s, prod_y_s, rext, sx, sy;
	logic signed [CW-1:0]             px_s, py_s;

	assign rad  = signed'({1'b0, cfg.radius});
	assign mx   = cos_s * rad;
	assign my   = sin_s * rad;
	assign rext = signed'(PW'(cfg.radius));
	assign sx   = prod_x_s + RND;
	assign sy   = prod_y_s + RND;

	always_ff @(posedge clk) begin
		prod_x_s <= mx;
		prod_y_s <= my;
		px_s     <= CW'((sx >>> 30) + rext);
		py_s     <= CW'((sy >>> 30) + rext);
	end

	assign px = px_s;
	assign py = py_s;

endmodule

// File: rtl/aovg_normal.sv
// ----------------------------------------------------------------------------
// aovg_normal: unit normal of one polyline segment
// squared length, pipelined square root, per-component restoring division
// ----------------------------------------------------------------------------
module aovg_normal (
	input  logic                           clk,
	input  logic signed [aovg_pkg::CW-1:0] ax,
	input  logic signed [aovg_pkg::CW-1:0] ay,
	input  logic signed [aovg_pkg::CW-1:0] bx,
	input  logic signed [aovg_pkg::CW-1:0] by,
	output logic signed [aovg_pkg::UW-1:0] ux,
	output logic signed [aovg_pkg::UW-1:0] uy
);
	localparam int NW  = aovg_pkg::NW;
	localparam int MW  = aovg_pkg::MW;
	localparam int SW  = aovg_pkg::SW;
	localparam int SQW = aovg_pkg::SQW;
	localparam int RTW = aovg_pkg::RTW;
	localparam int RMW = aovg_pkg::RMW;
	localparam int QW  = aovg_pkg::QW;
	localparam int DVW = aovg_pkg::DVW;
	localparam int UW  = aovg_pkg::UW;

	// segment normal (a.y-b.y, b.x-a.x)
	logic signed [NW-1:0] nx_s1, ny_s1;

	always_ff @(posedge clk) begin
		nx_s1 <= NW'(ay - by);
		ny_s1 <= NW'(bx - ax);
	end

	// squares and magnitudes
	logic signed [SW-1:0] xx, yy;
	logic [SW-2:0]        xx_s2, yy_s2;
	aovg_pkg::nrm_side_t  side_s2, side_s3;
	logic [SW-1:0]        s_s3;

	assign xx = nx_s1 * nx_s1;
	assign yy = ny_s1 * ny_s1;

	always_ff @(posedge clk) begin
		xx_s2      <= xx[SW-2:0];
		yy_s2      <= yy[SW-2:0];
		side_s2.mx <= nx_s1[NW-1] ? MW'(-nx_s1) : MW'(nx_s1);
		side_s2.my <= ny_s1[NW-1] ? MW'(-ny_s1) : MW'(ny_s1);
		side_s2.sx <= nx_s1[NW-1];
		side_s2.sy <= ny_s1[NW-1];
		s_s3       <= {1'b0, xx_s2} + {1'b0, yy_s2};
		side_s3    <= side_s2;
	end

	// square root of s*2^16, two operand bits per stage
	logic [SQW-1:0]      sq_v_s    [RTW];
	logic [RMW-1:0]      sq_rem_s  [RTW];
	logic [RTW-1:0]      sq_root_s [RTW];
	aovg_pkg::nrm_side_t sq_side_s [RTW];

	for (genvar j = 0; j < RTW; j++) begin : g_sqrt
		logic [SQW-1:0]      v_in;
		logic [RMW-1:0]      rem_in, remt, trial;
		logic [RTW-1:0]      root_in;
		aovg_pkg::nrm_side_t side_in;
		logic                ge;

		if (j == 0) begin : g_first
			assign v_in    = {s_s3, 16'b0};
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = side_s3;
		end else begin : g_next
			assign v_in    = sq_v_s[j-1];
			assign rem_in  = sq_rem_s[j-1];
			assign root_in = sq_root_s[j-1];
			assign side_in = sq_side_s[j-1];
		end

		assign remt  = {rem_in[RMW-3:0], v_in[SQW-1:SQW-2]};
		assign trial = RMW'({root_in, 2'b01});
		assign ge    = remt >= trial;

		always_ff @(posedge clk) begin
			sq_v_s[j]    <= v_in << 2;
			sq_rem_s[j]  <= ge ? remt - trial : remt;
			sq_root_s[j] <= {root_in[RTW-2:0], ge};
			sq_side_s[j] <= side_in;
		end
	end

	// |n| * 2^25 / len for both components
	logic [DVW-1:0]      dv_rx_s  [QW];
	logic [DVW-1:0]      dv_ry_s  [QW];
	logic [QW-1:0]       dv_qx_s  [QW];
	logic [QW-1:0]       dv_qy_s  [QW];
	logic [RTW-1:0]      dv_len_s [QW];
	aovg_pkg::nrm_side_t dv_side_s[QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [DVW-1:0]      rx_in, ry_in, dsh;
		logic [QW-1:0]       qx_in, qy_in;
		logic [RTW-1:0]      len_in;
		aovg_pkg::nrm_side_t side_in;
		logic                gex, gey;

		if (j == 0) begin : g_first
			assign rx_in   = {sq_side_s[RTW-1].mx, 25'b0};
			assign ry_in   = {sq_side_s[RTW-1].my, 25'b0};
			assign qx_in   = '0;
			assign qy_in   = '0;
			assign len_in  = sq_root_s[RTW-1];
			assign side_in = sq_side_s[RTW-1];
		end else begin : g_next
			assign rx_in   = dv_rx_s[j-1];
			assign ry_in   = dv_ry_s[j-1];
			assign qx_in   = dv_qx_s[j-1];
			assign qy_in   = dv_qy_s[j-1];
			assign len_in  = dv_len_s[j-1];
			assign side_in = dv_side_s[j-1];
		end

		assign dsh = DVW'(len_in) << (QW - 1 - j);
		assign gex = rx_in >= dsh;
		assign gey = ry_in >= dsh;

		always_ff @(posedge clk) begin
			dv_rx_s[j]   <= gex ? rx_in - dsh : rx_in;
			dv_ry_s[j]   <= gey ? ry_in - dsh : ry_in;
			dv_qx_s[j]   <= {qx_in[QW-2:0], gex};
			dv_qy_s[j]   <= {qy_in[QW-2:0], gey};
			dv_len_s[j]  <= len_in;
			dv_side_s[j] <= side_in;
		end
	end

	// round to 16 fraction bits, apply sign; zero length gives zero
	logic [QW:0]          tx, ty;
	logic                 len_zero;
	logic signed [UW-1:0] mag_x, mag_y, unit_x_s, unit_y_s;

	assign tx       = {1'b0, dv_qx_s[QW-1]} + 1'b1;
	assign ty       = {1'b0, dv_qy_s[QW-1]} + 1'b1;
	assign len_zero = dv_len_s[QW-1] == '0;
	assign mag_x    = len_zero ? '0 : signed'(UW'(tx[QW:1]));
	assign mag_y    = len_zero ? '0 : signed'(UW'(ty[QW:1]));

	always_ff @(posedge clk) begin
		unit_x_s <= dv_side_s[QW-1].sx ? -mag_x : mag_x;
		unit_y_s <= dv_side_s[QW-1].sy ? -mag_y : mag_y;
	end

	assign ux = unit_x_s;
	assign uy = unit_y_s;

endmodule

// File: rtl/arc_outline_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// arc_outline_vertex_generator_core: inner/outer outline vertex of an arc
// one vertex request per clock, fixed latency, results strobed by done
// ----------------------------------------------------------------------------
// A request (start high, vertex_number) is taken in every cycle; busy is
// always low. Each request yields exactly one result, shown on the result
// ports for one cycle with done high. The delay from the request to its
// result is set by the pipeline depth: the arc point (53-step phase
// division, 16 cordic steps, radius multiply), the segment normals (31-step
// square root, 18-step division) and the thickness offset with the result
// register. Results come out in request order and cannot be held off, so
// the receiver must take them. A vertex with fewer than three points in use
// or a vertex number not below the point count gives a result with
// valid_res low and zero coordinates. The user must write the registers
// through wr_en/wr_index/wr_data only while no request is in flight; the
// block does not enforce this. Indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module arc_outline_vertex_generator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// register write port
	input  logic                              wr_en,
	input  logic [aovg_pkg::WR_IW-1:0]        wr_index,
	input  logic [aovg_pkg::WR_DW-1:0]        wr_data,
	// request side
	input  logic                              start,
	output logic                              busy,
	input  logic [9:0]                        vertex_number,
	// result side
	output logic                              done,
	output logic                              valid_res,
	output logic signed [23:0]                inner_x,
	output logic signed [23:0]                inner_y,
	output logic signed [23:0]                outer_x,
	output logic signed [23:0]                outer_y
);
	localparam int CW  = aovg_pkg::CW;
	localparam int UW  = aovg_pkg::UW;
	localparam int OW  = aovg_pkg::OW;
	localparam int TW  = aovg_pkg::TW;
	localparam int DW  = aovg_pkg::DW;
	localparam int KW  = aovg_pkg::KW;
	localparam int NM  = aovg_pkg::NM_LAT;
	localparam int TOT = aovg_pkg::TOT_LAT;
	localparam logic signed [OW-1:0] RND    = OW'(64'sd32768);
	localparam logic signed [OW-1:0] SAT_HI = OW'(64'sd8388607);
	localparam logic signed [OW-1:0] SAT_LO = OW'(-64'sd8388608);

	// configuration registers
	logic [19:0]        radius_q;
	logic [10:0]        point_count_q;
	logic signed [9:0]  start_angle_q;
	logic signed [9:0]  end_angle_q;
	logic signed [15:0] thickness_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= '0;
			point_count_q <= 11'd32;
			start_angle_q <= '0;
			end_angle_q   <= 10'sd360;
			thickness_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				aovg_pkg::REG_RADIUS:      radius_q      <= wr_data;
				aovg_pkg::REG_POINT_COUNT: point_count_q <= wr_data[10:0];
				aovg_pkg::REG_START_ANGLE: start_angle_q <= signed'(wr_data[9:0]);
				aovg_pkg::REG_END_ANGLE:   end_angle_q   <= signed'(wr_data[9:0]);
				aovg_pkg::REG_THICKNESS:   thickness_q   <= signed'(wr_data[15:0]);
				default: ;
			endcase
		end
	end

	// arc setup; user keeps it stable with requests in flight, unchecked
	logic signed [9:0]  ang_lo, ang_hi;
	logic signed [10:0] span;
	logic [11:0]        base0, base1, base2;
	logic [10:0]        n_eff;
	aovg_pkg::arc_cfg_t arc_cfg;

	assign ang_lo = (start_angle_q < end_angle_q) ? start_angle_q : end_angle_q;
	assign ang_hi = (start_angle_q < end_angle_q) ? end_angle_q : start_angle_q;
	assign span   = 11'(ang_hi) - 11'(ang_lo);

	// (lo + 90) mod 360 in 0..359: shift to positive, then two reductions
	assign base0 = 12'(ang_lo) + 12'd810;
	assign base1 = (base0 >= 12'd720) ? base0 - 12'd720 : base0;
	assign base2 = (base1 >= 12'd360) ? base1 - 12'd360 : base1;

	// point count clamped to the point limit
	assign n_eff = (point_count_q > 11'(aovg_pkg::MAX_POINTS)) ?
	               11'(aovg_pkg::MAX_POINTS) : point_count_q;

	assign arc_cfg.radius  = radius_q;
	assign arc_cfg.range   = span[9:0];
	assign arc_cfg.nbase   = DW'(n_eff) * DW'(base2[8:0]);
	assign arc_cfg.divisor = DW'(n_eff) * DW'(360);

	// request decode: point triple, vertex zero wraps back to point N
	logic          accept, in_range;
	logic [KW-1:0] k0, k1, k2;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign in_range = (n_eff >= 11'd3) && ({1'b0, vertex_number} < n_eff);
	assign k0       = (vertex_number == '0) ? n_eff : KW'(vertex_number);
	assign k1       = KW'(vertex_number) + KW'(1);
	assign k2       = KW'(vertex_number) + KW'(2);

	// three arc points in parallel
	logic signed [CW-1:0] p0x, p0y, p1x, p1y, p2x, p2y;

	aovg_point u_point0 (.clk(clk), .cfg(arc_cfg), .k(k0), .px(p0x), .py(p0y));
	aovg_point u_point1 (.clk(clk), .cfg(arc_cfg), .k(k1), .px(p1x), .py(p1y));
	aovg_point u_point2 (.clk(clk), .cfg(arc_cfg), .k(k2), .px(p2x), .py(p2y));

	// unit normals of both segments
	logic signed [UW-1:0] na_x, na_y, nb_x, nb_y;

	aovg_normal u_normal_a (
		.clk(clk), .ax(p0x), .ay(p0y), .bx(p1x), .by(p1y), .ux(na_x), .uy(na_y)
	);
	aovg_normal u_normal_b (
		.clk(clk), .ax(p1x), .ay(p1y), .bx(p2x), .by(p2y), .ux(nb_x), .uy(nb_y)
	);

	// request valid and range flag travel alongside the data
	logic [TOT-1:0] vld_s;
	logic [TOT-1:0] ok_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			ok_s  <= '0;
		end else begin
			vld_s <= {vld_s[TOT-2:0], accept};
			ok_s  <= {ok_s[TOT-2:0], in_range};
		end
	end

	// middle point waits for the normals
	logic signed [CW-1:0] mid_x_s [NM+1];
	logic signed [CW-1:0] mid_y_s [NM+1];

	always_ff @(posedge clk) begin
		mid_x_s[0] <= p1x;
		mid_y_s[0] <= p1y;
		for (int m = 1; m <= NM; m++) begin
			mid_x_s[m] <= mid_x_s[m-1];
			mid_y_s[m] <= mid_y_s[m-1];
		end
	end

	// normal sum times thickness
	logic signed [UW:0]   nsum_x, nsum_y;
	logic signed [OW-1:0] off_x_s1, off_y_s1;

	assign nsum_x = UW'(na_x) + UW'(nb_x) + (UW+1)'(0);
	assign nsum_y = UW'(na_y) + UW'(nb_y) + (UW+1)'(0);

	always_ff @(posedge clk) begin
		off_x_s1 <= nsum_x * TW'(thickness_q);
		off_y_s1 <= nsum_y * TW'(thickness_q);
	end

	// round the offset, add to the middle point, saturate
	logic signed [OW-1:0] ox, oy, sat_x, sat_y;

	assign ox = ((off_x_s1 + RND) >>> 16) + OW'(mid_x_s[NM]);
	assign oy = ((off_y_s1 + RND) >>> 16) + OW'(mid_y_s[NM]);
	assign sat_x = (ox > SAT_HI) ? SAT_HI : ((ox < SAT_LO) ? SAT_LO : ox);
	assign sat_y = (oy > SAT_HI) ? SAT_HI : ((oy < SAT_LO) ? SAT_LO : oy);

	// result registers; out-of-range vertices give zeros
	logic                 res_ok_s2;
	logic signed [23:0]   inner_x_s2, inner_y_s2, outer_x_s2, outer_y_s2;

	always_ff @(posedge clk) begin
		res_ok_s2 <= ok_s[TOT-2];
		if (ok_s[TOT-2]) begin
			inner_x_s2 <= 24'(mid_x_s[NM]);
			inner_y_s2 <= 24'(mid_y_s[NM]);
			outer_x_s2 <= 24'(sat_x);
			outer_y_s2 <= 24'(sat_y);
		end else begin
			inner_x_s2 <= '0;
			inner_y_s2 <= '0;
			outer_x_s2 <= '0;
			outer_y_s2 <= '0;
		end
	end

	assign done      = vld_s[TOT-1];
	assign valid_res = res_ok_s2;
	assign inner_x   = inner_x_s2;
	assign inner_y   = inner_y_s2;
	assign outer_x   = outer_x_s2;
	assign outer_y   = outer_y_s2;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for arc_outline_vertex_generator_core
// drives vertex requests under several register settings, predicts each
// inner/outer vertex with a bit-exact fixed point model or takes it from
// the directed table, and checks each strobed result in order against it
// ----------------------------------------------------------------------------
module tb_top;

	// index past the end of the register list, writes must be dropped
	localparam logic [aovg_pkg::WR_IW-1:0] REG_NONE = 3'd5;

	typedef struct {
		logic        ok;
		logic [23:0] ix;
		logic [23:0] iy;
		logic [23:0] ox;
		logic [23:0] oy;
	} vertex_t;

	typedef enum int {ROW_WRITE, ROW_SEND, ROW_SEND_EXP} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		logic [aovg_pkg::WR_IW-1:0] idx;
		int                         val;
		vertex_t                    exp;
	} row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          wr_en = 1'b0;
	logic [aovg_pkg::WR_IW-1:0]    wr_index = '0;
	logic [aovg_pkg::WR_DW-1:0]    wr_data = '0;
	logic                          start = 1'b0;
	logic [9:0]                    vertex_number = '0;
	logic                          busy;
	logic                          done;
	logic                          valid_res;
	logic signed [23:0]            inner_x;
	logic signed [23:0]            inner_y;
	logic signed [23:0]            outer_x;
	logic signed [23:0]            outer_y;

	// shadow copy of the register file
	logic [19:0] sh_radius = 20'd0;
	logic [10:0] sh_points = 11'd32;
	logic [9:0]  sh_start  = 10'd0;
	logic [9:0]  sh_end    = 10'd360;
	logic [15:0] sh_thick  = 16'd0;

	vertex_t pending_vertices[$];
	int      mismatches = 0;

	arc_outline_vertex_generator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.start         (start),
		.busy          (busy),
		.vertex_number (vertex_number),
		.done          (done),
		.valid_res     (valid_res),
		.inner_x       (inner_x),
		.inner_y       (inner_y),
		.outer_x       (outer_x),
		.outer_y       (outer_y)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// fixed point vertex predictor
	// ------------------------------------------------------------------

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint clip24(longint v);
		if (v > 64'sd8388607)
			return 64'sd8388607;
		if (v < -64'sd8388608)
			return -64'sd8388608;
		return v;
	endfunction

	// cos/sin of a binary phase, 30 fraction bits
	function automatic void rotate_phase(logic [31:0] phase, output longint c,
			output longint s);
		logic [1:0]  quad;
		logic [31:0] resid;
		longint      x, y, z, t;
		quad = 2'((phase + 32'h2000_0000) >> 30);
		resid = phase - {quad, 30'd0};
		z = longint'(signed'(resid));
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < aovg_pkg::CORDIC_STEPS && i < aovg_pkg::ATAN_LEN; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(aovg_pkg::ATAN_TAB[i]);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(aovg_pkg::ATAN_TAB[i]);
			end
			x = t;
		end
		case (quad)
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic void arc_position(longint unsigned k, longint unsigned n,
			output longint px, output longint py);
		longint          a, b, lo, hi, r, c, s;
		longint unsigned span, base, num;
		logic [31:0]     phase;
		a = longint'(signed'(sh_start));
		b = longint'(signed'(sh_end));
		lo = a < b ? a : b;
		hi = a < b ? b : a;
		span = longint'(hi - lo);
		base = longint'((((lo + 90) % 360) + 360) % 360);
		num = (k * span + n * base) << 32;
		phase = 32'(num / (360 * n));
		rotate_phase(phase, c, s);
		r = longint'(sh_radius);
		px = r + ((c * r + (64'sd1 <<< 29)) >>> 30);
		py = r + ((s * r + (64'sd1 <<< 29)) >>> 30);
	endfunction

	function automatic longint unit_part(longint v, longint unsigned len);
		longint unsigned mag, q;
		if (len == 0)
			return 0;
		mag = v < 0 ? -v : v;
		q = (((mag << 25) / len) + 1) >> 1;
		return v < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic void seg_normal(longint ax, longint ay, longint bx,
			longint by, output longint ux, output longint uy);
		longint          nx, ny;
		longint unsigned len;
		nx = ay - by;
		ny = bx - ax;
		len = int_sqrt((longint'(nx * nx) + longint'(ny * ny)) << 16);
		ux = unit_part(nx, len);
		uy = unit_part(ny, len);
	endfunction

	function automatic vertex_t predict_vertex(logic [9:0] vn);
		vertex_t         res;
		longint unsigned n, i;
		longint          x0, y0, x1, y1, x2, y2, ax, ay, bx, by, t;
		res = '{1'b0, 24'd0, 24'd0, 24'd0, 24'd0};
		i = vn;
		n = sh_points < aovg_pkg::MAX_POINTS ? sh_points : aovg_pkg::MAX_POINTS;
		if (n < 3 || i >= n)
			return res;
		arc_position(i == 0 ? n : i, n, x0, y0);
		arc_position(i + 1, n, x1, y1);
		arc_position(i + 2, n, x2, y2);
		seg_normal(x0, y0, x1, y1, ax, ay);
		seg_normal(x1, y1, x2, y2, bx, by);
		t = longint'(signed'(sh_thick));
		res.ok = 1'b1;
		res.ix = 24'(clip24(x1));
		res.iy = 24'(clip24(y1));
		res.ox = 24'(clip24(x1 + (((ax + bx) * t + (64'sd1 <<< 15)) >>> 16)));
		res.oy = 24'(clip24(y1 + (((ay + by) * t + (64'sd1 <<< 15)) >>> 16)));
		return res;
	endfunction

	// ------------------------------------------------------------------
	// result checker, results cannot be held off so sample every edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && done) begin
			if (pending_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: valid=%0b inner=(%0d,%0d) outer=(%0d,%0d)",
						valid_res, inner_x, inner_y, outer_x, outer_y);
			end else begin
				want = pending_vertices.pop_front();
				if (valid_res !== want.ok || inner_x !== want.ix || inner_y !== want.iy ||
						outer_x !== want.ox || outer_y !== want.oy) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: exp valid=%0b inner=(%0d,%0d) outer=(%0d,%0d)",
							want.ok, signed'(want.ix), signed'(want.iy),
							signed'(want.ox), signed'(want.oy));
						$display(" got valid=%0b inner=(%0d,%0d) outer=(%0d,%0d)",
							valid_res, inner_x, inner_y, outer_x, outer_y);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// request and register drivers
	// ------------------------------------------------------------------

	// wait for the pipeline to drain before touching registers
	task automatic drain_pipe();
		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (aovg_pkg::TOT_LAT + 4) @(posedge clk);
	endtask

	// wr_en is left high; the caller lowers it after the last write
	task automatic write_reg(logic [aovg_pkg::WR_IW-1:0] idx, int val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= aovg_pkg::WR_DW'(val);
		@(posedge clk);
		case (idx)
			aovg_pkg::REG_RADIUS:      sh_radius = 20'(val);
			aovg_pkg::REG_POINT_COUNT: sh_points = 11'(val);
			aovg_pkg::REG_START_ANGLE: sh_start  = 10'(val);
			aovg_pkg::REG_END_ANGLE:   sh_end    = 10'(val);
			aovg_pkg::REG_THICKNESS:   sh_thick  = 16'(val);
			default: ;
		endcase
	endtask

	// one request; start stays high after it, the caller decides on gaps
	task automatic send_vertex(logic [9:0] vn, logic typed, vertex_t exp);
		start <= 1'b1;
		vertex_number <= vn;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_vertices.push_back(typed ? exp : predict_vertex(vn));
	endtask

	// idle cycles between requests, mostly none or short, a few long
	task automatic sender_gap();
		int g, pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			g = 0;
		else if (pick < 92)
			g = $urandom_range(1, 3);
		else
			g = $urandom_range(10, 60);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic int rand_angle();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1023);
		return $urandom_range(0, 720) - 360;
	endfunction

	row_t dir_rows[$];

	task automatic add_write(logic [aovg_pkg::WR_IW-1:0] idx, int val);
		dir_rows.push_back('{ROW_WRITE, idx, val, '{1'b0, 24'd0, 24'd0, 24'd0, 24'd0}});
	endtask

	task automatic add_send(int vn);
		dir_rows.push_back('{ROW_SEND, aovg_pkg::REG_RADIUS, vn,
			'{1'b0, 24'd0, 24'd0, 24'd0, 24'd0}});
	endtask

	task automatic add_typed(int vn, logic ok);
		dir_rows.push_back('{ROW_SEND_EXP, aovg_pkg::REG_RADIUS, vn,
			'{ok, 24'd0, 24'd0, 24'd0, 24'd0}});
	endtask

	initial begin
		int n_use, steps;
		vertex_t none;
		none = '{1'b0, 24'd0, 24'd0, 24'd0, 24'd0};

		// reset defaults: zero radius puts every point at the origin
		add_typed(0, 1'b1);
		add_typed(31, 1'b1);
		add_typed(32, 1'b0);
		add_typed(1023, 1'b0);
		// smallest valid polyline, angles at +360 and -360, full positive offset
		add_write(aovg_pkg::REG_RADIUS, 100 << 8);
		add_write(aovg_pkg::REG_POINT_COUNT, 3);
		add_write(aovg_pkg::REG_START_ANGLE, 360);
		add_write(aovg_pkg::REG_END_ANGLE, -360);
		add_write(aovg_pkg::REG_THICKNESS, 32767);
		add_send(0);
		add_send(1);
		add_send(2);
		add_typed(3, 1'b0);
		// largest radius, full point count, out-of-range angles, negative offset
		add_write(aovg_pkg::REG_RADIUS, 1048575);
		add_write(aovg_pkg::REG_POINT_COUNT, 1024);
		add_write(aovg_pkg::REG_START_ANGLE, -512);
		add_write(aovg_pkg::REG_END_ANGLE, 511);
		add_write(aovg_pkg::REG_THICKNESS, -32768);
		add_write(REG_NONE, 12345);
		add_send(0);
		add_send(512);
		add_send(1023);
		// point count above the limit is clipped
		add_write(aovg_pkg::REG_POINT_COUNT, 2047);
		add_send(1023);
		add_send(681);
		// too few points: everything invalid
		add_write(aovg_pkg::REG_POINT_COUNT, 2);
		add_typed(0, 1'b0);
		add_typed(1, 1'b0);
		// equal angles collapse segments to zero length
		add_write(aovg_pkg::REG_POINT_COUNT, 8);
		add_write(aovg_pkg::REG_START_ANGLE, 45);
		add_write(aovg_pkg::REG_END_ANGLE, 45);
		add_send(0);
		add_send(7);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < dir_rows.size(); r++) begin
			if (dir_rows[r].kind == ROW_WRITE) begin
				if (r == 0 || dir_rows[r-1].kind != ROW_WRITE) begin
					start <= 1'b0;
					drain_pipe();
				end
				write_reg(dir_rows[r].idx, dir_rows[r].val);
				if (r + 1 == dir_rows.size() || dir_rows[r+1].kind != ROW_WRITE)
					wr_en <= 1'b0;
			end else begin
				send_vertex(10'(dir_rows[r].val), dir_rows[r].kind == ROW_SEND_EXP,
					dir_rows[r].exp);
				sender_gap();
			end
		end

		// random phases: fresh registers, then a burst of vertices
		for (int ph = 0; ph < 10; ph++) begin
			start <= 1'b0;
			drain_pipe();
			case ($urandom_range(0, 5))
				0: write_reg(aovg_pkg::REG_RADIUS, 0);
				1: write_reg(aovg_pkg::REG_RADIUS, 1048575);
				2: write_reg(aovg_pkg::REG_RADIUS, $urandom_range(0, 1048575));
				default: write_reg(aovg_pkg::REG_RADIUS, $urandom_range(256, 200 << 8));
			endcase
			case ($urandom_range(0, 7))
				0: write_reg(aovg_pkg::REG_POINT_COUNT, $urandom_range(0, 3));
				1: write_reg(aovg_pkg::REG_POINT_COUNT, 1024);
				2: write_reg(aovg_pkg::REG_POINT_COUNT, $urandom_range(1025, 2047));
				default: write_reg(aovg_pkg::REG_POINT_COUNT, $urandom_range(3, 1023));
			endcase
			write_reg(aovg_pkg::REG_START_ANGLE, rand_angle());
			write_reg(aovg_pkg::REG_END_ANGLE, rand_angle());
			case ($urandom_range(0, 3))
				0: write_reg(aovg_pkg::REG_THICKNESS, -32768);
				1: write_reg(aovg_pkg::REG_THICKNESS, 32767);
				default: write_reg(aovg_pkg::REG_THICKNESS, $urandom_range(0, 65535));
			endcase
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_NONE + 3'($urandom_range(0, 2)), $urandom_range(0, 1048575));
			wr_en <= 1'b0;
			n_use = sh_points < aovg_pkg::MAX_POINTS ? sh_points : aovg_pkg::MAX_POINTS;
			steps = 120 + $urandom_range(0, 20);
			for (int k = 0; k < steps; k++) begin
				// mostly in-range vertices, some just past the end, some raw noise
				if ($urandom_range(0, 9) < 7 && n_use > 0)
					send_vertex(10'($urandom_range(0, n_use - 1)), 1'b0, none);
				else if ($urandom_range(0, 1) == 0)
					send_vertex(10'(n_use + $urandom_range(0, 2)), 1'b0, none);
				else
					send_vertex(10'($urandom_range(0, 1023)), 1'b0, none);
				// a stretch with no gaps in some phases
				if (ph % 3 != 1)
					sender_gap();
			end
		end

		start <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (aovg_pkg::TOT_LAT + 10) @(posedge clk);
		if (mismatches == 0)
			$display("arc_outline_vertex_generator_core regression: pass");
		else
			$display("arc_outline_vertex_generator_core regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("arc_outline_vertex_generator_core regression: fail");
		$finish;
	end

endmodule

// File: files.f
rtl/aovg_pkg.sv
rtl/aovg_point.sv
rtl/aovg_normal.sv
rtl/arc_outline_vertex_generator_core.sv
tb/tb_top.sv
